FILE: rtl/crp_pkg.sv
`default_nettype none

package crp_pkg;

  localparam int unsigned SET_DEPTH = 32;
  localparam int unsigned PAGE_BITS = 20;
  localparam int unsigned SLOT_W    = $clog2(SET_DEPTH);
  localparam int unsigned CNT_W     = $clog2(SET_DEPTH + 1);
  localparam int unsigned LIM_W     = 6;
  localparam int unsigned CMP_W     = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(32);

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_PLACE   = 2'd1,
    OUT_REPLACE = 2'd2
  } outcome_e;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic                 is_write;
  } in_t;

  typedef struct packed {
    outcome_e             outcome;
    logic [SLOT_W-1:0]    slot_index;
    logic [PAGE_BITS-1:0] victim_page;
    logic                 needs_writeback;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic compare;
    logic decide;
    logic scan;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic free;
    logic found;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/crp_ctrl.sv
`default_nettype none

module crp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire crp_pkg::sts_t sts_i,
  output crp_pkg::cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_DECIDE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = (sts_i.hit || sts_i.free) ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.found) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/crp_datapath.sv
`default_nettype none

module crp_datapath (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire crp_pkg::in_t                    in_data_i,
  input  wire logic                            cfg_valid_i,
  input  wire logic [crp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [crp_pkg::LIM_W-1:0]       cfg_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output crp_pkg::out_t                        out_data_o,
  input  wire crp_pkg::cmd_t                   cmd_i,
  output crp_pkg::sts_t                        sts_o
);

  localparam int unsigned DEPTH = crp_pkg::SET_DEPTH;
  localparam int unsigned SW    = crp_pkg::SLOT_W;
  localparam int unsigned CW    = crp_pkg::CNT_W;
  localparam int unsigned MW    = crp_pkg::CMP_W;

  logic [crp_pkg::PAGE_BITS-1:0] tags_q [DEPTH];
  logic [DEPTH-1:0]              used_q, mod_q, match_q, match_d;
  logic [CW-1:0]                 filled_q, k_q;
  logic [SW-1:0]                 hand_q, pos_q;
  logic [1:0]                    pass_q;
  logic                          policy_q;
  logic [crp_pkg::LIM_W-1:0]     limit_q;
  crp_pkg::in_t                  item_q;
  crp_pkg::out_t                 res_q, out_q;
  logic                          out_valid_q;

  logic [MW-1:0] lim_raw, eff_lim;
  logic [CW-1:0] filled_inc, pos_inc;
  logic [SW-1:0] hit_idx, pos_next, scan_start;
  logic          hit_any, free, want_mod0, found, last_in_pass;

  // effective limit: 0 acts as 1, clamp to depth
  always_comb begin
    lim_raw = MW'(limit_q);
    if (lim_raw == '0) begin
      eff_lim = MW'(1);
    end else if (lim_raw > MW'(DEPTH)) begin
      eff_lim = MW'(DEPTH);
    end else begin
      eff_lim = lim_raw;
    end
  end

  assign free       = MW'(filled_q) < eff_lim;
  assign filled_inc = filled_q + 1'b1;

  // parallel tag compare over occupied slots
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (CW'(i) < filled_q) && (tags_q[i] == item_q.page_number);
    end
  end

  // lowest matching slot
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) hit_idx = SW'(i);
    end
  end
  assign hit_any = |match_q;

  // scan step: enhanced clock passes 0 and 2 also need modified clear
  assign want_mod0    = policy_q & ~pass_q[0];
  assign found        = !used_q[pos_q] && (!want_mod0 || !mod_q[pos_q]);
  assign pos_inc      = CW'(pos_q) + 1'b1;
  assign pos_next     = (pos_inc >= filled_q) ? '0 : pos_inc[SW-1:0];
  assign last_in_pass = (k_q == filled_q - 1'b1);
  assign scan_start   = (CW'(hand_q) < filled_q) ? hand_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      mod_q       <= '0;
      filled_q    <= '0;
      hand_q      <= '0;
      policy_q    <= 1'b0;
      limit_q     <= crp_pkg::LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          crp_pkg::CFG_POLICY: policy_q <= cfg_data_i[0];
          crp_pkg::CFG_LIMIT:  limit_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.decide) begin
        if (hit_any) begin
          used_q[hit_idx] <= 1'b1;
          if (item_q.is_write) mod_q[hit_idx] <= 1'b1;
        end else if (free) begin
          used_q[filled_q[SW-1:0]] <= 1'b1;
          mod_q[filled_q[SW-1:0]]  <= item_q.is_write;
          filled_q                 <= filled_inc;
          if (MW'(filled_inc) == eff_lim) hand_q <= '0;
        end
      end
      if (cmd_i.scan) begin
        if (found) begin
          used_q[pos_q] <= 1'b1;
          mod_q[pos_q]  <= item_q.is_write;
          hand_q        <= pos_next;
        end else if (!want_mod0) begin
          used_q[pos_q] <= 1'b0;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
    if (cmd_i.compare) match_q <= match_d;
    if (cmd_i.decide) begin
      pos_q  <= scan_start;
      k_q    <= '0;
      pass_q <= '0;
      res_q.victim_page     <= '0;
      res_q.needs_writeback <= 1'b0;
      if (hit_any) begin
        res_q.outcome    <= crp_pkg::OUT_HIT;
        res_q.slot_index <= hit_idx;
      end else begin
        res_q.outcome    <= crp_pkg::OUT_PLACE;
        res_q.slot_index <= filled_q[SW-1:0];
      end
    end
    if (cmd_i.scan) begin
      if (found) begin
        res_q.outcome         <= crp_pkg::OUT_REPLACE;
        res_q.slot_index      <= pos_q;
        res_q.victim_page     <= tags_q[pos_q];
        res_q.needs_writeback <= mod_q[pos_q];
      end else begin
        pos_q <= pos_next;
        if (last_in_pass) begin
          k_q    <= '0;
          pass_q <= pass_q + 1'b1;
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
    end
    if (cmd_i.load_out) out_q <= res_q;
  end

  // tag store
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && !hit_any && free) begin
      tags_q[filled_q[SW-1:0]] <= item_q.page_number;
    end else if (cmd_i.scan && found) begin
      tags_q[pos_q] <= item_q.page_number;
    end
  end

  assign sts_o.hit      = hit_any;
  assign sts_o.free     = free;
  assign sts_o.found    = found;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/clock_page_replacement_top.sv
// Clock / enhanced second-chance page replacement over a small working set.
// Input channel (in_valid_i/in_ready_o, in_data_i): one page reference per
// beat, page number plus a write flag. Output channel (out_valid_o/
// out_ready_i, out_data_o): one result beat per reference: hit, placed in
// a free slot, or replaced a victim, with the slot and write-back info.
// Config channel (cfg_valid_i/cfg_ready_o): index 0 policy (0 clock,
// 1 enhanced), index 1 set limit. Always ready; write only when idle.
// Flow: a hit or a free-slot fill goes from the accepting edge through the
// compare and decide states to the done state, which loads the output register.
// A replacement adds a victim scan that visits up to N+1 slots in clock mode
// and 3*N+1 in enhanced mode, N = occupied slots; the scan examines one slot
// per cycle through the used/modified bits.
// One reference is worked on at a time; the next is accepted once the
// previous result sits in the output register.
// A stalled receiver holds the result in the output register; a finished
// item then waits in the result register until the output register frees up.
// Reset (async, active low) empties the set, clears used/modified bits,
// hand and fill count, and loads policy 0, limit 32. Tags need no reset.
`default_nettype none

module clock_page_replacement_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire crp_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output crp_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [crp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [crp_pkg::LIM_W-1:0]     cfg_data_i
);

  crp_pkg::cmd_t cmd;
  crp_pkg::sts_t sts;

  // config beats are taken every cycle
  assign cfg_ready_o = 1'b1;

  crp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

FILE: rtl/crp_checker.sv
`default_nettype none

module crp_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_ready_o,
  input wire logic          out_valid_o,
  input wire logic          out_ready_i,
  input wire crp_pkg::out_t out_data_o
);

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed while stalled");

  // one reference in flight: busy right after accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  // a new result only appears while a reference is being worked on
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without reference in flight");

  // no eviction info unless a victim was replaced
  a_no_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.outcome != crp_pkg::OUT_REPLACE) |->
      (out_data_o.victim_page == '0) && !out_data_o.needs_writeback)
    else $error("victim info on hit or placement");

endmodule

bind clock_page_replacement_top crp_checker u_crp_checker (.*);

`default_nettype wire

FILE: tb/sv/clock_page_replacement_top_test.sv
`default_nettype none

module clock_page_replacement_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [crp_pkg::PAGE_BITS-1:0] page_t;
  typedef logic [crp_pkg::SLOT_W-1:0]    slot_t;
  typedef logic [crp_pkg::LIM_W-1:0]     lim_t;
  typedef logic [crp_pkg::CFG_IDX_W-1:0] idx_t;

  // Worst case per reference is a long send gap, a full 3*N+1 slot enhanced
  // scan and a long receiver stall. Summed over ~1600 references that still
  // stays well under this limit, which leaves plenty of margin.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned POOL_DEPTH  = 64;
  // Index the block has no register behind; a write there must change nothing.
  localparam idx_t CFG_SPARE = '1;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  crp_pkg::in_t  in_data   = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  crp_pkg::out_t out_data;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  idx_t          cfg_index = '0;
  lim_t          cfg_data  = '0;

  clock_page_replacement_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Working set shadow: tags, used and modified bits, fill count and hand,
  // plus the two config registers. Updated once per accepted reference beat.
  // ---------------------------------------------------------------------------
  page_t tag_q   [crp_pkg::SET_DEPTH];
  bit    used_q  [crp_pkg::SET_DEPTH];
  bit    dirty_q [crp_pkg::SET_DEPTH];
  int    fill_q   = 0;
  int    hand_q   = 0;
  int    scan_pos = 0;
  bit    pol_q    = 1'b0;
  lim_t  lim_q    = crp_pkg::LIMIT_RST;

  crp_pkg::in_t  ref_queue[$];     // references waiting to be driven
  crp_pkg::out_t result_queue[$];  // predicted results, oldest first
  page_t         page_pool [POOL_DEPTH];

  int          err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  bit          idle_en   = 1'b1;
  bit          in_beat   = 1'b0;
  int unsigned in_gap    = 0;
  int unsigned out_gap   = 0;

  initial begin
    for (int i = 0; i < crp_pkg::SET_DEPTH; i++) begin
      used_q[i]  = 1'b0;
      dirty_q[i] = 1'b0;
    end
  end

  // Limit 0 behaves as 1, anything above the depth as the full depth.
  function automatic int eff_lim();
    if (lim_q == '0) return 1;
    if (int'(lim_q) > crp_pkg::SET_DEPTH) return crp_pkg::SET_DEPTH;
    return int'(lim_q);
  endfunction

  // One sweep of n slots starting at scan_pos. want_clean also asks for
  // modified == 0; clear_used drops the used bit of each slot passed over.
  // Returns the victim, or n when the sweep found nothing.
  function automatic int sweep(int n, bit want_clean, bit clear_used);
    int p;
    int slot;
    p    = scan_pos;
    slot = n;
    for (int k = 0; k < n; k++) begin
      if (slot == n) begin
        if (!used_q[p] && (!want_clean || !dirty_q[p])) begin
          slot = p;
        end else begin
          if (clear_used) used_q[p] = 1'b0;
          p = (p + 1 >= n) ? 0 : p + 1;
        end
      end
    end
    scan_pos = p;
    return slot;
  endfunction

  function automatic crp_pkg::out_t resolve_ref(crp_pkg::in_t beat);
    crp_pkg::out_t res;
    int            n;
    int            lim;
    int            v;
    bit            found;
    res.outcome         = crp_pkg::OUT_HIT;
    res.slot_index      = '0;
    res.victim_page     = '0;
    res.needs_writeback = 1'b0;
    n     = fill_q;
    lim   = eff_lim();
    found = 1'b0;

    for (int i = 0; i < n; i++) begin
      if (!found && tag_q[i] == beat.page_number) begin
        found      = 1'b1;
        used_q[i]  = 1'b1;
        if (beat.is_write) dirty_q[i] = 1'b1;
        res.slot_index = slot_t'(i);
      end
    end
    if (found) return res;

    // Free slot: fill in order; hand restarts at 0 once the set is full.
    if (n < lim) begin
      tag_q[n]   = beat.page_number;
      used_q[n]  = 1'b1;
      dirty_q[n] = beat.is_write;
      fill_q     = n + 1;
      if (fill_q == lim) hand_q = 0;
      res.outcome    = crp_pkg::OUT_PLACE;
      res.slot_index = slot_t'(n);
      return res;
    end

    // Set full (or limit lowered under the fill): scan all occupied slots.
    scan_pos = (hand_q < n) ? hand_q : 0;
    if (!pol_q) begin
      v = sweep(n, 1'b0, 1'b1);
      if (v == n) v = sweep(n, 1'b0, 1'b1);
    end else begin
      v = sweep(n, 1'b1, 1'b0);
      if (v == n) v = sweep(n, 1'b0, 1'b1);
      if (v == n) v = sweep(n, 1'b1, 1'b0);
      if (v == n) v = sweep(n, 1'b0, 1'b1);
    end
    if (v >= n) v = 0;

    res.outcome         = crp_pkg::OUT_REPLACE;
    res.slot_index      = slot_t'(v);
    res.victim_page     = tag_q[v];
    res.needs_writeback = dirty_q[v];
    tag_q[v]   = beat.page_number;
    used_q[v]  = 1'b1;
    dirty_q[v] = beat.is_write;
    hand_q     = (v + 1 >= n) ? 0 : v + 1;
    return res;
  endfunction

  // Mostly back to back, often a short pause, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: new beats go out at the falling edge; a beat holds until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_beat) begin
      // still waiting for in_ready, hold payload
    end else if (in_gap > 0) begin
      in_gap   <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (ref_queue.size() > 0) begin
      in_data  <= ref_queue.pop_front();
      in_valid <= 1'b1;
      in_gap   <= pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver back-pressure: random stalls of the same shape as the send gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap   <= out_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_gap <= pick_gap();
    end
  end

  task automatic flag_field(string field, longint unsigned want, longint unsigned got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge. The result check runs before the
  // prediction push, though a result never belongs to a same-edge reference.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    crp_pkg::out_t want;
    in_beat <= in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          $display("%0t: result beat with nothing expected, expected none, actual %h",
                   $time, out_data);
          err_cnt++;
        end else begin
          want = result_queue.pop_front();
          if (want.outcome != out_data.outcome)
            flag_field("outcome", want.outcome, out_data.outcome);
          if (want.slot_index != out_data.slot_index)
            flag_field("slot_index", want.slot_index, out_data.slot_index);
          if (want.victim_page != out_data.victim_page)
            flag_field("victim_page", want.victim_page, out_data.victim_page);
          if (want.needs_writeback != out_data.needs_writeback)
            flag_field("needs_writeback", want.needs_writeback, out_data.needs_writeback);
        end
      end
      if (in_valid && in_ready) result_queue.push_back(resolve_ref(in_data));
    end
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle: nothing queued, nothing on the input, every result back.
  // Checked just after the rising edge so all edge updates have settled.
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (ref_queue.size() != 0 || in_valid || result_queue.size() != 0);
  endtask

  // Holds cfg_valid high across back-to-back writes; cfg_close drops it.
  task automatic cfg_write(idx_t idx, lim_t data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == crp_pkg::CFG_POLICY)     pol_q = data[0];
    else if (idx == crp_pkg::CFG_LIMIT) lim_q = data;
  endtask

  task automatic cfg_close();
    @(negedge clk);
    cfg_valid <= 1'b0;
    #1;
  endtask

  // Settle, then program both registers (and optionally poke the spare index).
  task automatic set_config(lim_t pol_data, lim_t lim_data, bit poke_spare);
    wait_idle();
    cfg_write(crp_pkg::CFG_POLICY, pol_data);
    cfg_write(crp_pkg::CFG_LIMIT, lim_data);
    if (poke_spare) cfg_write(CFG_SPARE, '1);
    cfg_close();
  endtask

  task automatic queue_ref(page_t pg, bit wr);
    crp_pkg::in_t item;
    item.page_number = pg;
    item.is_write    = wr;
    ref_queue.push_back(item);
  endtask

  // Random references: mostly drawn from a pool a bit larger than the
  // working set so hits and misses mix; some fresh pages refresh the pool.
  task automatic random_phase(int count, int wr_pct);
    int    size;
    int    pool_n;
    int    r;
    page_t pg;
    size   = (fill_q >= eff_lim()) ? fill_q : eff_lim();
    pool_n = size + size / 2 + 2;
    if (pool_n > POOL_DEPTH) pool_n = POOL_DEPTH;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        pg = page_pool[$urandom_range(0, pool_n - 1)];
      end else if (r < 96) begin
        pg = page_t'($urandom);
        if ($urandom_range(0, 1)) page_pool[$urandom_range(0, pool_n - 1)] = pg;
      end else begin
        pg = $urandom_range(0, 1) ? '1 : '0;
      end
      queue_ref(pg, $urandom_range(0, 99) < wr_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int lims [12];
    int wr_mix [3];
    lims   = '{4, 10, 0, 16, 63, 2, 24, 32, 1, 40, 32, 8};
    wr_mix = '{10, 50, 90};

    for (int i = 0; i < POOL_DEPTH; i++) page_pool[i] = page_t'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    #1;

    // Reset config (clock, limit 32): fills from slot 0, hit with write.
    queue_ref('0, 1'b0);
    queue_ref('1, 1'b1);
    queue_ref('0, 1'b1);

    // Limit 3, policy bit 0 with the upper data bits set: set fills, then
    // clock replacement over an all-used set (clearing pass, write-back).
    set_config(6'b111110, 6'd3, 1'b0);
    queue_ref(20'h12345, 1'b0);
    queue_ref(20'hABCDE, 1'b0);
    queue_ref('1, 1'b0);
    queue_ref(20'h55555, 1'b1);
    queue_ref('0, 1'b0);
    queue_ref(20'hABCDE, 1'b1);

    // Enhanced mode: mixes of used/modified across the four passes.
    set_config(6'b000001, 6'd3, 1'b0);
    queue_ref(20'hABCDE, 1'b0);
    queue_ref(20'h11111, 1'b1);
    queue_ref(20'h22222, 1'b0);
    queue_ref(20'h33333, 1'b1);
    queue_ref('0, 1'b0);
    queue_ref('1, 1'b1);

    // Limit lowered under the fill: set counts as full, does not shrink.
    set_config(6'b000001, 6'd1, 1'b0);
    queue_ref(20'h44444, 1'b0);
    queue_ref(20'h66666, 1'b1);
    queue_ref(20'h44444, 1'b0);

    // Limit 0 behaves as 1; spare config index must have no effect.
    set_config(6'b101010, 6'd0, 1'b1);
    queue_ref(20'h77777, 1'b0);
    queue_ref(20'h88888, 1'b0);

    // Limit raised after full: fill resumes at slot 3, hand kept until full.
    set_config(6'b101010, 6'd5, 1'b0);
    queue_ref(20'h99999, 1'b1);
    queue_ref(20'hAAAAA, 1'b0);
    queue_ref(20'hBBBBB, 1'b0);

    // Limit above the depth behaves as the depth.
    set_config(6'b010101, 6'd63, 1'b0);
    queue_ref(20'hCCCCC, 1'b1);
    queue_ref(20'hDDDDD, 1'b0);

    // Random phases; every fourth one runs without any idling.
    for (int p = 0; p < 12; p++) begin
      set_config({5'($urandom), 1'((p / 2) % 2)}, lim_t'(lims[p]), 1'b0);
      idle_en = (p % 4) != 3;
      random_phase(131, wr_mix[$urandom_range(0, 2)]);
    end

    wait_idle();
    // Tail: give any stray result beat time to show up.
    repeat (16) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: clock_page_replacement_top.f
rtl/crp_pkg.sv
rtl/crp_ctrl.sv
rtl/crp_datapath.sv
rtl/clock_page_replacement_top.sv
rtl/crp_checker.sv
tb/sv/clock_page_replacement_top_test.sv
